// ===== src/ttwm_pkg.sv =====
package ttwm_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int MIN_YEAR      = 15;

    localparam logic [4:0] DAY_MAX    = 5'd31;
    localparam logic [3:0] MONTH_MAX  = 4'd12;
    localparam logic [4:0] HOUR_LIM   = 5'd24;
    localparam logic [5:0] MINUTE_LIM = 6'd60;
    localparam logic [15:0] DATE_NONE = 16'h0000;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_EVAL  = 1'b1;

    localparam logic REG_TASK_COUNT = 1'b0;
    localparam logic REG_SCHED_EN   = 1'b1;

    localparam logic [1:0] SRC_EVERYDAY = 2'd0;
    localparam logic [1:0] SRC_DATED    = 2'd1;
    localparam logic [1:0] SRC_MANUAL   = 2'd2;
    localparam logic [1:0] SRC_NONE     = 2'd3;

    localparam int ENTRY_W = 71;

endpackage

// ===== src/timed_task_window_matcher.sv =====
// timed task window matcher
// input channel (i_valid/o_ready) carries one beat per item: a write beat
// (i_operation low) stores a task entry at i_task_index, an evaluate beat
// (i_operation high) carries the current date/clock and manual device word.
// output channel (o_valid/i_ready) returns exactly one beat per input beat,
// in order. the apb port holds task_count (0x0) and schedule_enabled (0x4).
// a write beat, or an evaluate with the schedule off or no tasks, goes from
// idle to the finish state and then into the output register. an evaluate
// with n tasks in use scans the table twice, first for everyday tasks then
// for dated ones, one entry read per cycle from a single-port table memory
// with registered read data, and ends the scan when an entry matches.
// one item is in work at a time; o_ready is high while idle.
// a finished result sits in an output register, so the next beat is
// accepted while the result waits; if the receiver stalls, the following
// result waits in the block until the output register frees up.
// reset clears the control state and the registers (task_count 0,
// schedule_enabled 1, no previous report); the task table is not cleared
// and entries must be written before they are used.
module timed_task_window_matcher #(
    parameter int MAX_TASKS = ttwm_pkg::MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [2:0]  i_task_index,
    input  logic        i_everyday,
    input  logic [15:0] i_first_date,
    input  logic [10:0] i_first_clock,
    input  logic [15:0] i_second_date,
    input  logic [10:0] i_second_clock,
    input  logic [15:0] i_device_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_entry_ok,
    output logic [1:0]  o_source,
    output logic [2:0]  o_matched_task,
    output logic [15:0] o_devices_out,
    output logic        o_changed,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ttwm_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} t_state;

    t_state r_state;

    logic [3:0] r_task_count;
    logic       r_sched_en;

    logic [ENTRY_W-1:0] r_mem [MAX_TASKS];
    logic [ENTRY_W-1:0] r_rd_data;

    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_rd_cnt;
    logic [IDX_W-1:0] r_cmp_idx;
    logic             r_cmp_valid;
    logic             r_pass;
    logic [15:0]      r_now_date;
    logic [10:0]      r_now_clock;

    logic        r_res_ok;
    logic [1:0]  r_res_src;
    logic [2:0]  r_res_task;
    logic [15:0] r_res_dev;
    logic        r_res_is_write;

    logic [1:0] r_last_src;
    logic [2:0] r_last_task;

    logic        r_out_valid;
    logic        r_out_ok;
    logic [1:0]  r_out_src;
    logic [2:0]  r_out_task;
    logic [15:0] r_out_dev;
    logic        r_out_changed;

    logic               accept;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               wr_ok;
    logic               rd_en;
    logic [CNT_W-1:0]   n_sat;
    logic               match;
    logic               rd_everyday;
    logic [15:0]        rd_dev;
    logic [15:0]        rd_bdate;
    logic [10:0]        rd_bclock;
    logic [10:0]        rd_eclock;
    logic [26:0]        rd_begin;
    logic [26:0]        rd_end;
    logic [26:0]        now;
    logic               cfg_wr;
    logic               out_load;

    function automatic logic date_ok(input logic [15:0] d);
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
        day   = d[4:0];
        month = d[8:5];
        year  = d[15:9];
        return !(day > DAY_MAX || month > MONTH_MAX || year < 7'(MIN_YEAR));
    endfunction

    function automatic logic clock_ok(input logic [10:0] c);
        return (c[10:6] < HOUR_LIM) && (c[5:0] < MINUTE_LIM);
    endfunction

    // write checks
    always_comb begin
        wr_ok = date_ok(i_first_date) && clock_ok(i_first_clock) && clock_ok(i_second_clock);
        if (i_everyday) begin
            wr_ok = wr_ok && (i_second_date == DATE_NONE);
        end else begin
            wr_ok = wr_ok && date_ok(i_second_date);
        end
    end

    assign accept  = i_valid && (r_state == S_IDLE);
    assign wr_en   = accept && (i_operation == OP_WRITE)
                     && (32'(i_task_index) < 32'(MAX_TASKS));
    assign wr_addr = IDX_W'(i_task_index);
    assign wr_data = {i_everyday, i_device_word, i_first_date, i_first_clock,
                      i_second_date, i_second_clock};

    assign n_sat = (32'(r_task_count) > 32'(MAX_TASKS)) ? CNT_W'(MAX_TASKS)
                                                         : CNT_W'(r_task_count);

    assign rd_everyday = r_rd_data[70];
    assign rd_dev      = r_rd_data[69:54];
    assign rd_bdate    = r_rd_data[53:38];
    assign rd_bclock   = r_rd_data[37:27];
    assign rd_eclock   = r_rd_data[10:0];
    assign rd_begin    = r_rd_data[53:27];
    assign rd_end      = r_rd_data[26:0];
    assign now         = {r_now_date, r_now_clock};

    always_comb begin
        if (r_pass) begin
            match = r_cmp_valid && !rd_everyday && (rd_begin <= now) && (rd_end > now);
        end else begin
            match = r_cmp_valid && rd_everyday && (rd_bdate <= r_now_date)
                    && (rd_bclock <= r_now_clock) && (rd_eclock > r_now_clock);
        end
    end

    assign rd_en = (r_state == S_SCAN) && !match && (r_rd_cnt < r_n);

    // task table
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[r_rd_cnt[IDX_W-1:0]];
        end
    end

    // configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= '0;
            r_sched_en   <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_TASK_COUNT: r_task_count <= pwdata[3:0];
                REG_SCHED_EN:   r_sched_en   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TASK_COUNT: prdata = {28'd0, r_task_count};
            REG_SCHED_EN:   prdata = {31'd0, r_sched_en};
            default:        prdata = '0;
        endcase
    end

    assign out_load = (r_state == S_FIN) && (!r_out_valid || i_ready);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cmp_valid <= 1'b0;
            r_last_src  <= SRC_NONE;
            r_last_task <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_src   <= SRC_MANUAL;
                        r_res_task  <= '0;
                        r_pass      <= 1'b0;
                        r_rd_cnt    <= '0;
                        r_cmp_valid <= 1'b0;
                        if (i_operation == OP_WRITE) begin
                            r_res_ok       <= wr_ok;
                            r_res_dev      <= '0;
                            r_res_is_write <= 1'b1;
                            r_state        <= S_FIN;
                        end else begin
                            r_res_ok       <= 1'b1;
                            r_res_dev      <= i_device_word;
                            r_res_is_write <= 1'b0;
                            r_now_date     <= i_first_date;
                            r_now_clock    <= i_first_clock;
                            r_n            <= n_sat;
                            r_state        <= (r_sched_en && n_sat != '0) ? S_SCAN : S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    if (match) begin
                        r_res_src   <= r_pass ? SRC_DATED : SRC_EVERYDAY;
                        r_res_task  <= 3'(r_cmp_idx);
                        r_res_dev   <= rd_dev;
                        r_cmp_valid <= 1'b0;
                        r_state     <= S_FIN;
                    end else if (rd_en) begin
                        r_cmp_valid <= 1'b1;
                        r_cmp_idx   <= r_rd_cnt[IDX_W-1:0];
                        r_rd_cnt    <= CNT_W'(r_rd_cnt + 1'b1);
                    end else if (r_cmp_valid) begin
                        r_cmp_valid <= 1'b0;
                    end else if (!r_pass) begin
                        r_pass   <= 1'b1;
                        r_rd_cnt <= '0;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_load) begin
                        r_out_ok    <= r_res_ok;
                        r_out_src   <= r_res_src;
                        r_out_task  <= r_res_task;
                        r_out_dev   <= r_res_dev;
                        r_state     <= S_IDLE;
                        if (r_res_is_write) begin
                            r_out_changed <= 1'b0;
                        end else if (r_res_src == SRC_MANUAL) begin
                            r_out_changed <= (r_last_src != SRC_MANUAL);
                            r_last_src    <= r_res_src;
                        end else begin
                            r_out_changed <= !((r_last_src == r_res_src)
                                               && (r_last_task == r_res_task));
                            r_last_src    <= r_res_src;
                            r_last_task   <= r_res_task;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_out_valid;
    assign o_entry_ok     = r_out_ok;
    assign o_source       = r_out_src;
    assign o_matched_task = r_out_task;
    assign o_devices_out  = r_out_dev;
    assign o_changed      = r_out_changed;

endmodule

// ===== src/ttwm_checker.sv =====
module ttwm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_entry_ok,
    input logic [1:0]  o_source,
    input logic [2:0]  o_matched_task,
    input logic [15:0] o_devices_out,
    input logic        o_changed
);
    import ttwm_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_source) && $stable(o_matched_task)
                                && $stable(o_devices_out) && $stable(o_changed))
        else $error("result beat changed while stalled");

    // a failed entry check only comes from a write beat
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_entry_ok |-> o_source == SRC_MANUAL && o_matched_task == 3'd0
                                   && o_devices_out == 16'd0 && !o_changed)
        else $error("failed write beat carries evaluate data");

    // a task match is an evaluate beat
    a_match_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_source == SRC_EVERYDAY || o_source == SRC_DATED) |-> o_entry_ok)
        else $error("task match without entry_ok");

    a_manual_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_source == SRC_MANUAL |-> o_matched_task == 3'd0)
        else $error("manual result with a task index");

    // the same task reported twice in a row is not a change
    a_repeat_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_source == SRC_EVERYDAY && o_matched_task == 3'd0 ##1
        o_valid && i_ready && o_source == SRC_EVERYDAY && o_matched_task == 3'd0
        |-> !o_changed)
        else $error("repeated everyday match flagged as change");

endmodule

bind timed_task_window_matcher ttwm_checker u_ttwm_checker (.*);
